// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Depth, count width, opcodes, status codes and the per-cell control word.
// ----------------------------------------------------------------------------
package spq_pkg;

    // number of cells in the sorted chain
    localparam int DEPTH = 16;
    // width of a counter that can hold DEPTH itself
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    // control word broadcast to every cell
    typedef struct packed {
        logic load;    // the chain changes this cycle
        logic insert;  // 1 insert, 0 remove
    } t_cell_ctrl;

endpackage

// ===== rtl/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq_cmd_if / spq_rsp_if: command and response channels
// Valid/ready channels carrying one command or one response per transfer.
// ----------------------------------------------------------------------------
interface spq_cmd_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic signed [DATA_W-1:0] new_value;
    logic signed [DATA_W-1:0] new_priority;

    modport source (output valid, output opcode, output new_value, output new_priority,
                    input ready);
    modport sink   (input valid, input opcode, input new_value, input new_priority,
                    output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] popped_priority;
    logic signed [DATA_W-1:0] head_value;
    logic signed [DATA_W-1:0] head_priority;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic                     is_full;

    modport source (output valid, output status, output popped_value,
                    output popped_priority, output head_value, output head_priority,
                    output entry_count, output is_empty, output is_full, input ready);
    modport sink   (input valid, input status, input popped_value,
                    input popped_priority, input head_value, input head_priority,
                    input entry_count, input is_empty, input is_full, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one pair; on insert keeps it, takes the new pair or takes the pair of
// its left neighbor; on remove takes the pair of its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
    input  logic                     i_clk,
    input  t_cell_ctrl               i_ctrl,
    input  logic                     i_occupied,
    input  logic                     i_left_keep,
    input  logic signed [DATA_W-1:0] i_new_value,
    input  logic signed [DATA_W-1:0] i_new_priority,
    input  logic signed [DATA_W-1:0] i_left_value,
    input  logic signed [DATA_W-1:0] i_left_priority,
    input  logic signed [DATA_W-1:0] i_right_value,
    input  logic signed [DATA_W-1:0] i_right_priority,
    output logic                     o_keep,
    output logic signed [DATA_W-1:0] o_value,
    output logic signed [DATA_W-1:0] o_priority,
    output logic signed [DATA_W-1:0] o_next_value,
    output logic signed [DATA_W-1:0] o_next_priority
);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] r_priority;
    logic signed [DATA_W-1:0] n_value;
    logic signed [DATA_W-1:0] n_priority;

    // stored pair stays ahead of the new one when its priority is not larger
    assign o_keep = i_occupied && (r_priority <= i_new_priority);

    // next pair of this slot
    always_comb begin
        n_value    = r_value;
        n_priority = r_priority;
        if (i_ctrl.load) begin
            if (i_ctrl.insert) begin
                if (o_keep) begin
                    n_value    = r_value;
                    n_priority = r_priority;
                end else if (i_left_keep) begin
                    n_value    = i_new_value;
                    n_priority = i_new_priority;
                end else begin
                    n_value    = i_left_value;
                    n_priority = i_left_priority;
                end
            end else begin
                n_value    = i_right_value;
                n_priority = i_right_priority;
            end
        end
    end

    // slot storage, no reset: contents count only below the fill level
    always_ff @(posedge i_clk) begin
        r_value    <= n_value;
        r_priority <= n_priority;
    end

    assign o_value         = r_value;
    assign o_priority      = r_priority;
    assign o_next_value    = n_value;
    assign o_next_priority = n_priority;

endmodule

// ===== rtl/sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: min-first sorted priority queue
// A chain of DEPTH cells kept sorted by priority; inserts and removes are
// done by all cells at once, with a registered response stage.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                         | handshake
//  ---------+-----+-------------------------------------------------+----------
//  i_cmd    | in  | opcode, new_value, new_priority                 | valid/ready
//  o_rsp    | out | status, popped and head pairs, count, flags     | valid/ready
//
//  One command per cycle while not stalled: every cell compares and
//  shifts in the same cycle, and the response register shows the result in
//  the cycle after the transfer. A new command is taken while the response
//  register is empty or drained. Reset clears the fill count and the
//  response valid; slots need no clear. A stalled response holds the command
//  side until it is taken.
module sorted_priority_queue_core import spq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    spq_cmd_if.sink  i_cmd,
    spq_rsp_if.source o_rsp
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             cmd_fire;
    logic             is_full_now;
    logic             is_empty_now;
    logic             op_ok;
    logic [STATUS_W-1:0] status_now;
    t_cell_ctrl       ctrl;

    logic                     keep      [DEPTH];
    logic signed [DATA_W-1:0] cur_value [DEPTH];
    logic signed [DATA_W-1:0] cur_prio  [DEPTH];
    logic signed [DATA_W-1:0] nxt_value [DEPTH];
    logic signed [DATA_W-1:0] nxt_prio  [DEPTH];

    logic                     r_out_valid;
    logic [STATUS_W-1:0]      r_status;
    logic signed [DATA_W-1:0] r_popped_value;
    logic signed [DATA_W-1:0] r_popped_priority;
    logic signed [DATA_W-1:0] r_head_value;
    logic signed [DATA_W-1:0] r_head_priority;
    logic [CNT_W-1:0]         r_out_count;

    // command transfer when the response stage can take the result
    assign i_cmd.ready = !r_out_valid || o_rsp.ready;
    assign cmd_fire    = i_cmd.valid && i_cmd.ready;

    // fill state and outcome of the current command
    assign is_full_now  = (r_count == CNT_W'(DEPTH));
    assign is_empty_now = (r_count == '0);

    always_comb begin
        status_now = ST_OK;
        op_ok      = 1'b1;
        n_count    = r_count;
        if (i_cmd.opcode == OP_INSERT) begin
            if (is_full_now) begin
                status_now = ST_OVERFLOW;
                op_ok      = 1'b0;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (is_empty_now) begin
                status_now = ST_UNDERFLOW;
                op_ok      = 1'b0;
            end else begin
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    assign ctrl.load   = cmd_fire && op_ok;
    assign ctrl.insert = (i_cmd.opcode == OP_INSERT);

    // chain of cells, head at index 0
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic                     left_keep;
        logic signed [DATA_W-1:0] left_value;
        logic signed [DATA_W-1:0] left_prio;
        logic signed [DATA_W-1:0] right_value;
        logic signed [DATA_W-1:0] right_prio;

        if (gi == 0) begin : g_head
            assign left_keep  = 1'b1;
            assign left_value = i_cmd.new_value;
            assign left_prio  = i_cmd.new_priority;
        end else begin : g_body
            assign left_keep  = keep[gi-1];
            assign left_value = cur_value[gi-1];
            assign left_prio  = cur_prio[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign right_value = i_cmd.new_value;
            assign right_prio  = i_cmd.new_priority;
        end else begin : g_inner
            assign right_value = cur_value[gi+1];
            assign right_prio  = cur_prio[gi+1];
        end

        spq_cell u_cell (
            .i_clk            (i_clk),
            .i_ctrl           (ctrl),
            .i_occupied       (CNT_W'(gi) < r_count),
            .i_left_keep      (left_keep),
            .i_new_value      (i_cmd.new_value),
            .i_new_priority   (i_cmd.new_priority),
            .i_left_value     (left_value),
            .i_left_priority  (left_prio),
            .i_right_value    (right_value),
            .i_right_priority (right_prio),
            .o_keep           (keep[gi]),
            .o_value          (cur_value[gi]),
            .o_priority       (cur_prio[gi]),
            .o_next_value     (nxt_value[gi]),
            .o_next_priority  (nxt_prio[gi])
        );
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (ctrl.load) begin
            r_count <= n_count;
        end
    end

    // response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (cmd_fire) begin
            r_status    <= status_now;
            r_out_count <= n_count;
            if (ctrl.load && !ctrl.insert) begin
                r_popped_value    <= cur_value[0];
                r_popped_priority <= cur_prio[0];
            end else begin
                r_popped_value    <= '0;
                r_popped_priority <= '0;
            end
            if (n_count != '0) begin
                r_head_value    <= nxt_value[0];
                r_head_priority <= nxt_prio[0];
            end else begin
                r_head_value    <= '0;
                r_head_priority <= '0;
            end
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_status;
    assign o_rsp.popped_value    = r_popped_value;
    assign o_rsp.popped_priority = r_popped_priority;
    assign o_rsp.head_value      = r_head_value;
    assign o_rsp.head_priority   = r_head_priority;
    assign o_rsp.entry_count     = COUNT_W'(r_out_count);
    assign o_rsp.is_empty        = (r_out_count == '0);
    assign o_rsp.is_full         = (r_out_count == CNT_W'(DEPTH));

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sorted priority queue core
// Drives insert and remove commands with random gaps, predicts every
// response with a behavioral sorted store and compares all fields.
// ----------------------------------------------------------------------------
module testbench;
    import spq_pkg::*;

    typedef struct {
        logic                     opcode;
        logic signed [DATA_W-1:0] new_value;
        logic signed [DATA_W-1:0] new_priority;
    } t_queue_cmd;

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] popped_value;
        logic signed [DATA_W-1:0] popped_priority;
        logic signed [DATA_W-1:0] head_value;
        logic signed [DATA_W-1:0] head_priority;
        logic [COUNT_W-1:0]       entry_count;
        logic                     is_empty;
        logic                     is_full;
    } t_queue_rsp;

    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;

    logic i_clk;
    logic i_rst_n;

    spq_cmd_if cmd_if ();
    spq_rsp_if rsp_if ();

    sorted_priority_queue_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    // commands waiting to be sent, responses waiting to arrive
    t_queue_cmd pending_cmds[$];
    t_queue_rsp expected_rsps[$];

    // shadow copy of the sorted store
    logic signed [DATA_W-1:0] shadow_values[DEPTH];
    logic signed [DATA_W-1:0] shadow_prios[DEPTH];
    int shadow_count;

    int mismatch_count;
    int accepted_count;
    int send_gap;
    int recv_stall;
    bit calm;
    bit hold_off;
    int insert_bias;
    int bias_left;

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        cmd_if.valid        = 1'b0;
        cmd_if.opcode       = OP_INSERT;
        cmd_if.new_value    = '0;
        cmd_if.new_priority = '0;
        rsp_if.ready   = 1'b0;
        shadow_count   = 0;
        mismatch_count = 0;
        accepted_count = 0;
        send_gap       = 0;
        recv_stall     = 0;
        calm           = 1'b0;
        hold_off       = 1'b0;
        bias_left      = 0;
        insert_bias    = 50;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // apply one command to the shadow store and return the response it causes
    function automatic t_queue_rsp apply_queue_op(t_queue_cmd c);
        t_queue_rsp r;
        int pos;
        r.status          = ST_OK;
        r.popped_value    = '0;
        r.popped_priority = '0;
        r.head_value      = '0;
        r.head_priority   = '0;
        if (c.opcode == OP_INSERT) begin
            if (shadow_count >= DEPTH) begin
                r.status = ST_OVERFLOW;
            end else begin
                // new pair goes behind every pair of lower or equal priority
                pos = 0;
                while (pos < shadow_count && shadow_prios[pos] <= c.new_priority)
                    pos++;
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_values[i] = shadow_values[i-1];
                    shadow_prios[i]  = shadow_prios[i-1];
                end
                shadow_values[pos] = c.new_value;
                shadow_prios[pos]  = c.new_priority;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                r.status = ST_UNDERFLOW;
            end else begin
                r.popped_value    = shadow_values[0];
                r.popped_priority = shadow_prios[0];
                for (int i = 1; i < shadow_count; i++) begin
                    shadow_values[i-1] = shadow_values[i];
                    shadow_prios[i-1]  = shadow_prios[i];
                end
                shadow_count--;
            end
        end
        if (shadow_count > 0) begin
            r.head_value    = shadow_values[0];
            r.head_priority = shadow_prios[0];
        end
        r.entry_count = shadow_count[COUNT_W-1:0];
        r.is_empty    = (shadow_count == 0);
        r.is_full     = (shadow_count >= DEPTH);
        return r;
    endfunction

    function automatic void compare_field(string name, logic [DATA_W-1:0] got,
                                          logic [DATA_W-1:0] want);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch on %s at %0t: expected 0x%h, got 0x%h",
                         name, $realtime, want, got);
        end
    endfunction

    task automatic push_cmd(logic op, logic signed [DATA_W-1:0] val,
                            logic signed [DATA_W-1:0] pri);
        t_queue_cmd c;
        c.opcode       = op;
        c.new_value    = val;
        c.new_priority = pri;
        pending_cmds.push_back(c);
    endtask

    // random commands in phases that lean toward filling or draining
    task automatic add_random_cmds(int n);
        logic signed [DATA_W-1:0] pri;
        logic op;
        repeat (n) begin
            if (bias_left == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_bias = 20;
                    1: insert_bias = 50;
                    default: insert_bias = 85;
                endcase
                bias_left = $urandom_range(20, 50);
            end
            bias_left--;
            op = ($urandom_range(0, 99) < insert_bias) ? OP_INSERT : OP_REMOVE;
            case ($urandom_range(0, 3))
                0: pri = $signed($urandom_range(0, 8)) - 4;
                1: begin
                    case ($urandom_range(0, 3))
                        0: pri = INT_MIN;
                        1: pri = INT_MAX;
                        2: pri = '0;
                        default: pri = -1;
                    endcase
                end
                default: pri = $urandom;
            endcase
            push_cmd(op, $urandom, pri);
        end
    endtask

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                expected_rsps.push_back(apply_queue_op(pending_cmds.pop_front()));
                accepted_count++;
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    cmd_if.valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 9);
                    cmd_if.valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    cmd_if.valid        <= 1'b1;
                    cmd_if.opcode       <= pending_cmds[0].opcode;
                    cmd_if.new_value    <= pending_cmds[0].new_value;
                    cmd_if.new_priority <= pending_cmds[0].new_priority;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor and receiver stalls
    always @(posedge i_clk) begin
        t_queue_rsp want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_rsps.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected response transfer at %0t", $realtime);
                end else begin
                    want = expected_rsps.pop_front();
                    compare_field("status", DATA_W'(rsp_if.status), DATA_W'(want.status));
                    compare_field("popped_value", rsp_if.popped_value, want.popped_value);
                    compare_field("popped_priority", rsp_if.popped_priority,
                                  want.popped_priority);
                    compare_field("head_value", rsp_if.head_value, want.head_value);
                    compare_field("head_priority", rsp_if.head_priority,
                                  want.head_priority);
                    compare_field("entry_count", DATA_W'(rsp_if.entry_count),
                                  DATA_W'(want.entry_count));
                    compare_field("is_empty", DATA_W'(rsp_if.is_empty),
                                  DATA_W'(want.is_empty));
                    compare_field("is_full", DATA_W'(rsp_if.is_full),
                                  DATA_W'(want.is_full));
                end
            end
            if (hold_off) begin
                rsp_if.ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                rsp_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                recv_stall = $urandom_range(0, 9);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off so the core backs up and stalls commands
    initial begin
        wait (accepted_count >= 150);
        @(negedge i_clk);
        hold_off = 1'b1;
        repeat (80) @(negedge i_clk);
        hold_off = 1'b0;
    end

    // stimulus and end of run
    initial begin
        // remove from an empty store
        push_cmd(OP_REMOVE, 32'sd5, 32'sd5);
        // extreme values and priorities
        push_cmd(OP_INSERT, INT_MIN, INT_MAX);
        push_cmd(OP_INSERT, INT_MAX, INT_MIN);
        // equal priorities keep arrival order
        push_cmd(OP_INSERT, 32'sd11, 32'sd0);
        push_cmd(OP_INSERT, 32'sd12, 32'sd0);
        push_cmd(OP_INSERT, 32'sd13, 32'sd0);
        push_cmd(OP_INSERT, -32'sd1, -32'sd1);
        // fill up to full, then overflow
        for (int k = 0; k < DEPTH - 6; k++)
            push_cmd(OP_INSERT, $urandom, $urandom);
        push_cmd(OP_INSERT, 32'sd99, -32'sd7);
        push_cmd(OP_REMOVE, '0, '0);
        push_cmd(OP_REMOVE, INT_MIN, INT_MAX);
        push_cmd(OP_REMOVE, '0, '0);
        add_random_cmds(400);
        while (pending_cmds.size() != 0)
            @(negedge i_clk);
        // last stretch with no idling on either side
        calm = 1'b1;
        add_random_cmds(80);
        while (pending_cmds.size() != 0 || cmd_if.valid)
            @(negedge i_clk);
        while (expected_rsps.size() != 0)
            @(negedge i_clk);
        repeat (5) @(negedge i_clk);
        if (expected_rsps.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // run limit
    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sorted_priority_queue_core.f =====
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_core.sv
verif/testbench.sv
